// ===== design/signed_varint_byte_decoder_unit_defines.svh =====
// Assertion macros shared by the signed varint byte decoder RTL.
// Depends on nothing; included by every file that carries assertions.
`ifndef SIGNED_VARINT_BYTE_DECODER_UNIT_DEFINES_SVH
`define SIGNED_VARINT_BYTE_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SVBD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("svbd assertion failed");
`define SVBD_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("svbd assertion failed");
`else
`define SVBD_ASSERT(label, clk, rst, prop)
`define SVBD_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

// ===== design/svbd_pkg.sv =====
// Types, codes and the group base table of the signed varint byte decoder.
// Depends on nothing; used by every module of the block.
package svbd_pkg;

   localparam logic [7:0]  NullByte   = 8'h80;
   localparam logic [7:0]  PosPrefix  = 8'h7F;
   localparam logic [7:0]  NegPrefix  = 8'h81;
   localparam logic [31:0] NullCode   = 32'h8000_0000;
   localparam logic [2:0]  LastGroup  = 3'd4;

   typedef struct packed {
      logic       valid;
      logic [7:0] byte_value;
      logic       last_byte;
   } svbd_beat_type;

   typedef struct packed {
      logic        emit;
      logic [31:0] symbol;
   } svbd_result_type;

   function automatic logic [31:0] group_base(input logic [2:0] idx);
      logic [31:0] base;
      case (idx)
         3'd0:    base = 32'd127;
         3'd1:    base = 32'd255;
         3'd2:    base = 32'd16639;
         3'd3:    base = 32'd2113791;
         default: base = 32'd270549247;
      endcase
      return base;
   endfunction

endpackage

// ===== design/svbd_in_stage.sv =====
// Input register of the signed varint byte decoder.
// Depends on svbd_pkg.
module svbd_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_byte_value,
   input  logic                   req_last_byte,
   input  logic                   advance,
   output svbd_pkg::svbd_beat_type beat
);
   import svbd_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   assign req_ready = !valid_ff || advance;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         byte_ff <= req_byte_value;
         last_ff <= req_last_byte;
      end
   end

   assign beat.valid      = valid_ff;
   assign beat.byte_value = byte_ff;
   assign beat.last_byte  = last_ff;

endmodule

// ===== design/svbd_decode.sv =====
// Decoding state and the per-beat decode logic of the signed varint decoder.
// Depends on svbd_pkg and the assertion macros header.
`include "signed_varint_byte_decoder_unit_defines.svh"
module svbd_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  svbd_pkg::svbd_beat_type   beat,
   input  logic                     advance,
   output svbd_pkg::svbd_result_type res
);
   import svbd_pkg::*;

   logic        in_symbol_ff, in_symbol_in;
   logic        neg_ff, neg_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] acc_shift;
   logic [31:0] sum;
   logic [7:0]  b;

   assign b         = beat.byte_value;
   assign acc_shift = {acc_ff[24:0], b[6:0]};
   assign sum       = acc_shift + group_base(cnt_ff);

   always_comb begin
      in_symbol_in = in_symbol_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      res.emit     = 1'b0;
      res.symbol   = NullCode;
      if (!in_symbol_ff) begin
         if (b == NullByte) begin
            res.emit = 1'b1;
         end else if (b != PosPrefix && b != NegPrefix) begin
            res.emit   = 1'b1;
            res.symbol = {{24{b[7]}}, b};
         end else if (beat.last_byte) begin
            res.emit = 1'b1;
         end else begin
            in_symbol_in = 1'b1;
            neg_in       = (b == NegPrefix);
            acc_in       = '0;
            cnt_in       = '0;
         end
      end else begin
         if (!b[7]) begin
            res.emit   = 1'b1;
            res.symbol = neg_ff ? (~sum + 32'd1) : sum;
         end else if (cnt_ff == LastGroup) begin
            res.emit   = 1'b1;
            res.symbol = '0;
         end else if (beat.last_byte) begin
            res.emit = 1'b1;
         end else begin
            acc_in = acc_shift;
            cnt_in = cnt_ff + 3'd1;
         end
         if (res.emit) begin
            in_symbol_in = 1'b0;
            neg_in       = 1'b0;
            acc_in       = '0;
            cnt_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_symbol_ff <= 1'b0;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
      end else if (advance) begin
         in_symbol_ff <= in_symbol_in;
         neg_ff       <= neg_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
      end
   end

   `SVBD_ASSERT(cnt_bound_a, clock, reset, cnt_ff <= LastGroup)
   `SVBD_ASSERT(idle_clean_a, clock, reset, in_symbol_ff || (cnt_ff == '0 && !neg_ff && acc_ff == '0))
   `SVBD_ASSERT_NEXT(emit_idle_a, clock, reset, advance && res.emit, !in_symbol_ff)

endmodule

// ===== design/svbd_out_stage.sv =====
// Result register of the signed varint byte decoder.
// Depends on svbd_pkg.
module svbd_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  svbd_pkg::svbd_result_type res,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [31:0]       rsp_symbol
);
   import svbd_pkg::*;

   logic        valid_ff, valid_in;
   logic [31:0] symbol_ff;

   assign valid_in = (load && res.emit) || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load && res.emit) begin
         symbol_ff <= res.symbol;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_symbol = $signed(symbol_ff);

endmodule

// ===== design/signed_varint_byte_decoder_unit.sv =====
// Signed varint byte decoder: takes one byte per beat and returns a signed
// 32-bit symbol each time a code completes. The block accepts a byte in every
// cycle; a byte is held in the input register and decoded there against the
// decoding state register, and its symbol, if any, is offered from the result
// register. The rate is set by the single state update per byte, and it falls
// only while the result register holds a symbol that is not taken.
module signed_varint_byte_decoder_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_byte_value,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_symbol
);
   import svbd_pkg::*;

   svbd_beat_type   beat;
   svbd_result_type res;
   logic            advance;

   assign advance = beat.valid && (!rsp_valid || rsp_ready);

   svbd_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_value (req_byte_value),
      .req_last_byte  (req_last_byte),
      .advance        (advance),
      .beat           (beat)
   );

   svbd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .beat    (beat),
      .advance (advance),
      .res     (res)
   );

   svbd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .res        (res),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol)
   );

endmodule
